// ===== hw/rtl/rbdq_pkg.sv =====
// Shared constants, codes, types and pointer helpers for the ring buffer deque.
// No dependencies; imported by rbdq_ctrl and ring_buffer_deque_core.
package rbdq_pkg;

    // Build-time sizing
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Derived widths
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int IDX_W   = 4;
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int SUM_W   = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    // Port field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Store access issued by the controller
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } ram_req_t;

    // Per-transfer result fields, minus the store data
    typedef struct packed {
        logic                rd_ok;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } res_meta_t;

    // Circular pointer step forward
    function automatic logic [ADDR_W-1:0] slot_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Circular pointer step backward
    function automatic logic [ADDR_W-1:0] slot_prev(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// ===== hw/rtl/rbdq_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module rbdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rbdq_ctrl.sv =====
// Front/back pointers and element count; decodes each operation into a store
// access and the result status. Depends on rbdq_pkg.
module rbdq_ctrl
    import rbdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [OP_W-1:0]  operation,
    input  logic [IDX_W-1:0] index,
    output ram_req_t         ram_req,
    output res_meta_t        meta
);

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [ADDR_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  slot_sum;
    logic [SUM_W-1:0]  slot_wrap;
    logic [ADDR_W-1:0] read_slot;
    logic [ADDR_W-1:0] front_prev;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Logical index to physical slot; valid reads keep the sum below 2*DEPTH
    assign slot_sum   = SUM_W'(front_reg) + SUM_W'(index);
    assign slot_wrap  = (slot_sum >= SUM_W'(DEPTH)) ? slot_sum - SUM_W'(DEPTH) : slot_sum;
    assign read_slot  = slot_wrap[ADDR_W-1:0];
    assign front_prev = slot_prev(front_reg);

    // Operation decode
    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        ram_req.we  = 1'b0;
        ram_req.re  = 1'b0;
        ram_req.addr = read_slot;
        meta.rd_ok  = 1'b0;
        meta.status = ST_OK;
        case (operation)
            OP_PUSH_FRONT:
            begin
                ram_req.addr = front_prev;
                if (full)
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    front_next = front_prev;
                    count_next = count_reg + 1'b1;
                    ram_req.we = accept;
                end
            end
            OP_PUSH_BACK:
            begin
                ram_req.addr = back_reg;
                if (full)
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    back_next  = slot_next(back_reg);
                    count_next = count_reg + 1'b1;
                    ram_req.we = accept;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    front_next = slot_next(front_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    back_next  = slot_prev(back_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (CMP_W'(index) >= CMP_W'(count_reg))
                begin
                    meta.status = ST_RANGE;
                end
                else
                begin
                    meta.rd_ok = 1'b1;
                    ram_req.re = accept;
                end
            end
            default:
            begin
                meta.status = ST_OK;
            end
        endcase
        meta.count = COUNT_W'(count_next);
    end

    // Pointer and count state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ring_buffer_deque_core.sv =====
// Top level of the ring buffer deque: stream handshake, result stages, store.
// Depends on rbdq_pkg, rbdq_ctrl and rbdq_ram.
//
// Fixed-capacity double-ended queue of DEPTH entries held in one single-port
// synchronous RAM. Each input transfer carries one operation (push front, push
// back, pop front, pop back, read at logical index) and yields exactly one
// output transfer with read data, status and the element count after the
// operation. One operation is taken per clock cycle while s_tready is high; a
// result passes through the registered read of the store and then the output
// register. Pointer and count updates finish in the accept cycle, so
// back-to-back operations on the same entry see each other without interlock.
// Backpressure on the output stalls the input only when both result stages
// are occupied.
module ring_buffer_deque_core
    import rbdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // push_value[31:0], index[35:32], zero pad
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_data[31:0], element_count[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic       accept;
    ram_req_t   ram_req;
    res_meta_t  meta;
    logic [STORE_W-1:0] rdata;

    logic       p1_valid_reg;
    res_meta_t  p1_meta_reg;
    logic       out_valid_reg;
    logic [VALUE_W-1:0]  out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic       out_free;
    logic       p1_move;

    // Handshake: stage 1 drains into the output register when it is free
    assign out_free = !out_valid_reg || m_tready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    rbdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (s_tuser),
        .index     (s_tdata[35:32]),
        .ram_req   (ram_req),
        .meta      (meta)
    );

    rbdq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (s_tdata[STORE_W-1:0]),
        .rdata (rdata)
    );

    // Stage 1: waits on the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_valid_reg <= 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_meta_reg <= meta;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            out_data_reg   <= p1_meta_reg.rd_ok ? VALUE_W'(rdata) : '0;
            out_status_reg <= p1_meta_reg.status;
            out_count_reg  <= p1_meta_reg.count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule
